// File: rtl/core/lcg48_pkg.sv
package lcg48_pkg;

    // Field widths
    localparam int MODE_W = 3;
    localparam int SEED_W = 48;
    localparam int LEN_W  = 7;
    localparam int DATA_W = 64;
    localparam int WORD_W = 32;

    // Longest byte stream; longer requests saturate to it
    localparam logic [LEN_W-1:0] MAX_BYTES = 7'd64;
    localparam logic [LEN_W-1:0] UUID_BYTES = 7'd16;

    // Generator constants: multiplier split at bit 32, increment
    localparam logic [WORD_W-1:0] MUL_LO = 32'hDEEC_E66D;
    localparam logic [2:0]        MUL_HI = 3'd5;
    localparam logic [SEED_W-1:0] INCR   = 48'hB;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_RESEED = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WORD32 = 3'd1;
    localparam logic [MODE_W-1:0] MODE_WORD64 = 3'd2;
    localparam logic [MODE_W-1:0] MODE_BYTES  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_UUID   = 3'd4;

    // Output data selection
    localparam logic [1:0] SEL_WORD32 = 2'd0;
    localparam logic [1:0] SEL_WORD64 = 2'd1;
    localparam logic [1:0] SEL_BYTE   = 2'd2;

    // UUID byte positions with forced bits
    localparam logic [3:0] UUID_VER_POS = 4'd6;
    localparam logic [3:0] UUID_VAR_POS = 4'd8;

    // Commands from controller to datapath
    typedef struct packed {
        logic       load_seed;
        logic       mul;
        logic       add;
        logic       out_load;
        logic [1:0] out_sel;
        logic [1:0] byte_idx;
        logic       fix_ver;
        logic       fix_var;
        logic       last;
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

// File: rtl/core/lcg48_dp.sv
module lcg48_dp
    import lcg48_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_status        o_status,
    input  logic [SEED_W-1:0] i_seed_in,
    input  logic              i_stall,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data,
    output logic              o_last
);

    logic [SEED_W-1:0] r_seed;
    logic [SEED_W-1:0] r_plo;
    logic [15:0]       r_phi;
    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] r_hi;
    logic              r_valid;
    logic [DATA_W-1:0] r_data;
    logic              r_last;

    logic [2*WORD_W-1:0] lo_prod;
    logic [WORD_W-1:0]   hi_prod;
    logic [18:0]         five_prod;
    logic [15:0]         n_phi;
    logic [SEED_W-1:0]   n_seed;
    logic [7:0]          sel_byte;
    logic [7:0]          fix_byte;
    logic [DATA_W-1:0]   n_data;

    // Split the constant multiply: low 32x32 product, plus the small products
    // that land in the top 16 bits of the 48-bit result
    assign lo_prod   = {{WORD_W{1'b0}}, r_seed[WORD_W-1:0]} * {{WORD_W{1'b0}}, MUL_LO};
    assign hi_prod   = {16'd0, r_seed[SEED_W-1:WORD_W]} * {16'd0, MUL_LO[15:0]};
    assign five_prod = {3'd0, r_seed[15:0]} * {16'd0, MUL_HI};
    assign n_phi     = hi_prod[15:0] + five_prod[15:0];

    // Combine partial products and add the increment
    assign n_seed = r_plo + {r_phi, 32'd0} + INCR;

    // Pick one byte of the draw and force UUID version or variant bits
    always_comb begin
        sel_byte = r_word[8*i_cmd.byte_idx +: 8];
        fix_byte = sel_byte;
        if (i_cmd.fix_ver) begin
            fix_byte = {4'h4, sel_byte[3:0]};
        end else if (i_cmd.fix_var) begin
            fix_byte = {2'b10, sel_byte[5:0]};
        end
    end

    always_comb begin
        case (i_cmd.out_sel)
            SEL_WORD32: n_data = {32'd0, r_word};
            SEL_WORD64: n_data = {r_hi, r_word};
            SEL_BYTE:   n_data = {56'd0, fix_byte};
            default:    n_data = '0;
        endcase
    end

    // Seed and draw registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (i_cmd.load_seed) begin
            r_seed <= i_seed_in;
        end else if (i_cmd.add) begin
            r_seed <= n_seed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_plo <= lo_prod[SEED_W-1:0];
            r_phi <= n_phi;
        end
        if (i_cmd.add) begin
            r_word <= n_seed[SEED_W-1:16];
            r_hi   <= r_word;
        end
    end

    // Output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_data <= n_data;
            r_last <= i_cmd.last;
        end
    end

    assign o_status.out_free = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_last  = r_last;

endmodule

// File: rtl/core/lcg48_ctrl.sv
module lcg48_ctrl
    import lcg48_pkg::*;
#(
    parameter logic [LEN_W-1:0] MAX_LEN = MAX_BYTES
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [LEN_W-1:0]  i_byte_count,
    input  t_dp_status        i_status,
    output t_dp_cmd           o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_ADD  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [MODE_W-1:0] r_mode, n_mode;
    logic              r_second, n_second;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [1:0]        r_bidx, n_bidx;
    logic [3:0]        r_kcnt, n_kcnt;

    logic             accept;
    logic [LEN_W-1:0] sat_len;
    logic             is_word;
    logic             is_uuid;

    assign accept  = i_valid && (r_state == ST_IDLE);
    assign sat_len = (i_byte_count > MAX_LEN) ? MAX_LEN : i_byte_count;
    assign is_word = (r_mode == MODE_WORD32) || (r_mode == MODE_WORD64);
    assign is_uuid = (r_mode == MODE_UUID);
    assign o_stall = (r_state != ST_IDLE);

    // Sequence draws and emitted results
    always_comb begin
        n_state  = r_state;
        n_mode   = r_mode;
        n_second = r_second;
        n_len    = r_len;
        n_bidx   = r_bidx;
        n_kcnt   = r_kcnt;
        o_cmd    = '0;
        o_cmd.byte_idx = r_bidx;
        o_cmd.out_sel  = is_word ? ((r_mode == MODE_WORD64) ? SEL_WORD64 : SEL_WORD32)
                                 : SEL_BYTE;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_mode   = i_mode;
                    n_second = 1'b0;
                    n_kcnt   = '0;
                    case (i_mode)
                        MODE_RESEED: o_cmd.load_seed = 1'b1;
                        MODE_WORD32: n_state = ST_MUL;
                        MODE_WORD64: n_state = ST_MUL;
                        MODE_BYTES: begin
                            n_len = sat_len;
                            if (sat_len != '0) begin
                                n_state = ST_MUL;
                            end
                        end
                        MODE_UUID: begin
                            n_len   = UUID_BYTES;
                            n_state = ST_MUL;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_ADD;
            end
            ST_ADD: begin
                o_cmd.add = 1'b1;
                if ((r_mode == MODE_WORD64) && !r_second) begin
                    n_second = 1'b1;
                    n_state  = ST_MUL;
                end else begin
                    n_state = ST_EMIT;
                    // Full draw from byte 0; a short tail ends at byte 2
                    n_bidx = (r_len >= 7'd4) ? 2'd0 : (2'd3 - r_len[1:0]);
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (is_word) begin
                        o_cmd.last = 1'b1;
                        n_state    = ST_IDLE;
                    end else begin
                        o_cmd.fix_ver = is_uuid && (r_kcnt == UUID_VER_POS);
                        o_cmd.fix_var = is_uuid && (r_kcnt == UUID_VAR_POS);
                        o_cmd.last    = (r_len == 7'd1);
                        n_len  = r_len - 7'd1;
                        n_kcnt = r_kcnt + 4'd1;
                        if (r_len == 7'd1) begin
                            n_state = ST_IDLE;
                        end else if (r_bidx == 2'd3) begin
                            n_state = ST_MUL;
                        end else begin
                            n_bidx = r_bidx + 2'd1;
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_mode   <= MODE_RESEED;
            r_second <= 1'b0;
            r_len    <= '0;
            r_bidx   <= '0;
            r_kcnt   <= '0;
        end else begin
            r_state  <= n_state;
            r_mode   <= n_mode;
            r_second <= n_second;
            r_len    <= n_len;
            r_bidx   <= n_bidx;
            r_kcnt   <= n_kcnt;
        end
    end

endmodule

// File: rtl/core/lcg48_random_generator.sv
// Channel   Direction  Handshake          Payload
// request   in         i_valid / o_stall  i_mode, i_seed_in, i_byte_count
// result    out        o_valid / i_stall  o_data, o_last
//
// Each draw passes through the MUL and ADD states of the shared multiply/add
// datapath (partial products, then combine and add). Reseed loads the seed
// without a draw; word32 uses one draw and word64 two; a byte stream uses one
// draw per four bytes and a UUID four draws. Reset clears the seed to zero. A stalled
// result is held in the output register while the next draw proceeds.
module lcg48_random_generator
    import lcg48_pkg::*;
#(
    parameter logic [LEN_W-1:0] MAX_LEN = MAX_BYTES
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [SEED_W-1:0] i_seed_in,
    input  logic [LEN_W-1:0]  i_byte_count,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [DATA_W-1:0] o_data,
    output logic              o_last
);

    t_dp_cmd    cmd;
    t_dp_status status;

    lcg48_ctrl #(
        .MAX_LEN (MAX_LEN)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_mode       (i_mode),
        .i_byte_count (i_byte_count),
        .i_status     (status),
        .o_cmd        (cmd)
    );

    lcg48_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_status  (status),
        .i_seed_in (i_seed_in),
        .i_stall   (i_stall),
        .o_valid   (o_valid),
        .o_data    (o_data),
        .o_last    (o_last)
    );

endmodule
